@@ design/bref_pkg.sv @@
// ----------------------------------------------------------------------------
// bref_pkg: shared types and constants of the bucket run end finder
// Bucket geometry, the constant reciprocal used for the division by the
// bucket length, the token that travels along the cell chain, and the
// control state of the unit.
// ----------------------------------------------------------------------------
package bref_pkg;

    localparam int MAX_BUCKETS    = 64;
    localparam int BUCKET_SECONDS = 15 * 60;

    localparam int TIME_W   = 31;
    localparam int END_W    = 32;
    localparam int BUCKET_W = 22;
    localparam int CNT_W    = $clog2(MAX_BUCKETS + 1);

    // Count at which the drain timer deems a token injected into the first cell
    // to have left the last one, with any overflow it raised recorded.
    localparam int DRAIN_CYCLES = MAX_BUCKETS + 1;
    localparam int TIMER_W      = $clog2(DRAIN_CYCLES + 1);

    // time / 900 = (time / 4) / 225. For a 29-bit dividend the quotient by
    // 225 is exactly (x * RECIP) >> QUOT_SHIFT.
    localparam int QUARTER_W  = TIME_W - 2;
    localparam int RECIP_W    = 30;
    localparam int QUOT_SHIFT = 37;
    localparam int PROD_W     = QUOT_SHIFT + BUCKET_W;
    localparam logic [RECIP_W-1:0] RECIP = 30'd610839794;

    typedef logic [BUCKET_W-1:0] bucket_t;
    typedef logic [CNT_W-1:0]    count_t;

    // One bucket on its way along the chain. A lookup token only checks
    // membership and never takes a place in the store.
    typedef struct packed {
        logic    valid;
        logic    lookup;
        bucket_t bucket;
    } tok_t;

    // Bucket waiting at the head of the chain.
    typedef struct packed {
        logic    valid;
        logic    last;
        bucket_t bucket;
    } stage_t;

    // Result handed to the output stage.
    typedef struct packed {
        logic    load;
        logic    last;
        logic    ovf;
        bucket_t bucket;
    } emit_t;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_DRAIN,
        ST_EMIT
    } state_t;

endpackage

@@ design/bref_in_if.sv @@
// ----------------------------------------------------------------------------
// bref_in_if: input channel of the bucket run end finder
// One bar time per transaction, with a flag on the final time of a set.
// ----------------------------------------------------------------------------
interface bref_in_if;

    logic                           valid;
    logic                           ready;
    logic [bref_pkg::TIME_W-1:0]    bar_time;
    logic                           last_item;

    modport source (
        output valid,
        output bar_time,
        output last_item,
        input  ready
    );

    modport sink (
        input  valid,
        input  bar_time,
        input  last_item,
        output ready
    );

endinterface

@@ design/bref_out_if.sv @@
// ----------------------------------------------------------------------------
// bref_out_if: output channel of the bucket run end finder
// One run end point per transaction, with final and overflow flags.
// ----------------------------------------------------------------------------
interface bref_out_if;

    logic                           valid;
    logic                           ready;
    logic [bref_pkg::END_W-1:0]     end_point;
    logic                           last_result;
    logic                           overflowed;

    modport source (
        output valid,
        output end_point,
        output last_result,
        output overflowed,
        input  ready
    );

    modport sink (
        input  valid,
        input  end_point,
        input  last_result,
        input  overflowed,
        output ready
    );

endinterface

@@ design/bref_divider.sv @@
// ----------------------------------------------------------------------------
// bref_divider: bar time to bucket number
// Registers the product of the quartered time and the constant reciprocal
// of 225; the bucket number is the top slice of that product.
// ----------------------------------------------------------------------------
module bref_divider (
    input  logic             clk,
    input  logic             rst_n,
    bref_in_if.sink          bar,
    input  logic             take,
    output bref_pkg::stage_t stage
);

    logic                              valid_reg, valid_next;
    logic                              last_reg,  last_next;
    logic [bref_pkg::PROD_W-1:0]       prod_reg,  prod_next;
    logic [bref_pkg::QUARTER_W-1:0]    quarter;
    logic                              load;

    assign bar.ready = !valid_reg || take;
    assign load      = bar.valid && bar.ready;
    assign quarter   = bar.bar_time[bref_pkg::TIME_W-1:2];

    always_comb
    begin
        valid_next = valid_reg;
        last_next  = last_reg;
        prod_next  = prod_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = bar.last_item;
            prod_next  = bref_pkg::PROD_W'(quarter) * bref_pkg::PROD_W'(bref_pkg::RECIP);
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        prod_reg <= prod_next;
    end

    assign stage.valid  = valid_reg;
    assign stage.last   = last_reg;
    assign stage.bucket = prod_reg[bref_pkg::QUOT_SHIFT +: bref_pkg::BUCKET_W];

endmodule

@@ design/bref_cell.sv @@
// ----------------------------------------------------------------------------
// bref_cell: one place of the sorted bucket store
// Keeps the smaller of its own bucket and an arriving insert and hands the
// larger to the next cell; a lookup passes on, and an equal bucket is merged.
// During emission the cell takes its right neighbour's bucket instead.
// ----------------------------------------------------------------------------
module bref_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  bref_pkg::tok_t    tok_in,
    input  logic              occupied,
    input  logic              shift_en,
    input  bref_pkg::bucket_t shift_in,
    output bref_pkg::bucket_t held,
    output bref_pkg::tok_t    tok_out,
    output logic              settle
);

    bref_pkg::bucket_t held_reg, held_next;
    bref_pkg::tok_t    tok_reg,  tok_next;

    assign settle = tok_in.valid && !tok_in.lookup && !occupied;

    always_comb
    begin
        held_next = held_reg;
        tok_next  = '0;
        if (shift_en)
        begin
            held_next = shift_in;
        end
        else if (tok_in.valid)
        begin
            if (!occupied)
            begin
                if (tok_in.lookup)
                begin
                    tok_next = tok_in;
                end
                else
                begin
                    held_next = tok_in.bucket;
                end
            end
            else if (tok_in.bucket == held_reg)
            begin
                tok_next = '0;
            end
            else if (!tok_in.lookup && (tok_in.bucket < held_reg))
            begin
                held_next       = tok_in.bucket;
                tok_next.valid  = 1'b1;
                tok_next.lookup = 1'b0;
                tok_next.bucket = held_reg;
            end
            else
            begin
                tok_next = tok_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
    end

    assign held    = held_reg;
    assign tok_out = tok_reg;

endmodule

@@ design/bref_emitter.sv @@
// ----------------------------------------------------------------------------
// bref_emitter: output register of the run end points
// Turns the last bucket of a run into the start time of the following
// bucket and holds it until the transaction completes.
// ----------------------------------------------------------------------------
module bref_emitter (
    input  logic            clk,
    input  logic            rst_n,
    input  bref_pkg::emit_t emit,
    output logic            can_load,
    bref_out_if.source      ends
);

    logic                          valid_reg, valid_next;
    logic [bref_pkg::END_W-1:0]    point_reg, point_next;
    logic                          last_reg,  last_next;
    logic                          ovf_reg,   ovf_next;

    assign can_load = !valid_reg || ends.ready;

    always_comb
    begin
        valid_next = valid_reg;
        point_next = point_reg;
        last_next  = last_reg;
        ovf_next   = ovf_reg;
        if (emit.load)
        begin
            valid_next = 1'b1;
            point_next = bref_pkg::END_W'(
                (bref_pkg::END_W'(emit.bucket) + bref_pkg::END_W'(1))
                * bref_pkg::END_W'(bref_pkg::BUCKET_SECONDS));
            last_next  = emit.last;
            ovf_next   = emit.ovf;
        end
        else if (ends.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        point_reg <= point_next;
        last_reg  <= last_next;
        ovf_reg   <= ovf_next;
    end

    assign ends.valid       = valid_reg;
    assign ends.end_point   = point_reg;
    assign ends.last_result = last_reg;
    assign ends.overflowed  = ovf_reg;

endmodule

@@ design/bucket_run_end_finder_unit.sv @@
// ----------------------------------------------------------------------------
// bucket_run_end_finder_unit: ends of runs of consecutive 15-minute buckets
// Bar times are bucketed and inserted into a chain of cells that keeps the
// distinct buckets in ascending order; the flagged time triggers the
// streaming of one end point per run.
// ----------------------------------------------------------------------------
// Throughput: in the fill state, one bar time per cycle while the store has
// room for every bucket still travelling the chain; else input waits.
// Once the store is full, times are only looked up, again one per cycle.
// Emission: the flagged time passes the divider register, the chain drains
// until the drain timer expires, then the unit shifts out one stored bucket
// per cycle (output ready permitting) into the emitter register.
// Reset: asynchronous; empties the store and clears the overflow flag.
module bucket_run_end_finder_unit (
    input  logic       clk,
    input  logic       rst_n,
    bref_in_if.sink    bar,
    bref_out_if.source ends
);

    localparam int MAX = bref_pkg::MAX_BUCKETS;

    bref_pkg::state_t  state_reg, state_next;
    bref_pkg::stage_t  stage;
    bref_pkg::emit_t   emit;
    bref_pkg::count_t  count_reg, count_next;
    bref_pkg::count_t  bound_reg, bound_next;
    bref_pkg::count_t  bound_base;
    logic [bref_pkg::TIMER_W-1:0] timer_reg, timer_next;
    logic              ovf_reg, ovf_next;

    bref_pkg::tok_t    tok [0:MAX];
    bref_pkg::bucket_t held [0:MAX-1];
    logic [MAX-1:0]    occupied;
    logic [MAX-1:0]    settle_vec;

    logic take, settle, full, room, drained;
    logic inject, inject_ins, shift_en, has_next, run_end, can_load;

    bref_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .bar   (bar),
        .take  (take),
        .stage (stage)
    );

    for (genvar i = 0; i < MAX; i++)
    begin : g_cell
        bref_pkg::bucket_t shift_in;

        assign occupied[i] = count_reg > bref_pkg::CNT_W'(i);

        if (i == MAX - 1)
        begin : g_tail
            assign shift_in = '0;
        end
        else
        begin : g_body
            assign shift_in = held[i+1];
        end

        bref_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[i]),
            .occupied (occupied[i]),
            .shift_en (shift_en),
            .shift_in (shift_in),
            .held     (held[i]),
            .tok_out  (tok[i+1]),
            .settle   (settle_vec[i])
        );
    end

    bref_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .emit     (emit),
        .can_load (can_load),
        .ends     (ends)
    );

    // Only the cell at the fill boundary can take a bucket in any cycle.
    assign settle   = |settle_vec;
    assign full     = count_reg == bref_pkg::CNT_W'(MAX);
    assign room     = ({1'b0, count_reg} + {1'b0, bound_reg}) < (bref_pkg::CNT_W + 1)'(MAX);
    assign drained  = timer_reg == bref_pkg::TIMER_W'(bref_pkg::DRAIN_CYCLES);
    assign has_next = occupied[1];
    assign run_end  = !has_next || ((held[0] + bref_pkg::BUCKET_W'(1)) != held[1]);

    assign tok[0] = {inject, !inject_ins, stage.bucket};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            bref_pkg::ST_FILL:
            begin
                if (inject && stage.last)
                begin
                    state_next = bref_pkg::ST_DRAIN;
                end
            end
            bref_pkg::ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = bref_pkg::ST_EMIT;
                end
            end
            bref_pkg::ST_EMIT:
            begin
                if (shift_en && !has_next)
                begin
                    state_next = bref_pkg::ST_FILL;
                end
            end
            default:
            begin
                state_next = bref_pkg::ST_FILL;
            end
        endcase
    end

    // A full store turns new times into lookups, which may follow each other
    // freely; inserts wait while the buckets in flight could exceed capacity.
    always_comb
    begin
        inject     = 1'b0;
        inject_ins = 1'b0;
        shift_en   = 1'b0;
        case (state_reg)
            bref_pkg::ST_FILL:
            begin
                if (stage.valid)
                begin
                    if (full)
                    begin
                        inject = 1'b1;
                    end
                    else if (room)
                    begin
                        inject     = 1'b1;
                        inject_ins = 1'b1;
                    end
                end
            end
            bref_pkg::ST_DRAIN:
            begin
                inject = 1'b0;
            end
            bref_pkg::ST_EMIT:
            begin
                shift_en = can_load;
            end
            default:
            begin
                inject = 1'b0;
            end
        endcase
        take          = inject;
        emit.load     = shift_en && run_end;
        emit.last     = !has_next;
        emit.ovf      = ovf_reg;
        emit.bucket   = held[0];
    end

    always_comb
    begin
        count_next = count_reg;
        if (shift_en)
        begin
            count_next = count_reg - bref_pkg::CNT_W'(1);
        end
        else if (settle)
        begin
            count_next = count_reg + bref_pkg::CNT_W'(1);
        end

        // Once the chain is empty the bound on buckets in flight is exact.
        bound_base = drained ? '0 : bound_reg;
        bound_next = bound_base + bref_pkg::CNT_W'(inject_ins) - bref_pkg::CNT_W'(settle);

        if (inject)
        begin
            timer_next = '0;
        end
        else if (drained)
        begin
            timer_next = timer_reg;
        end
        else
        begin
            timer_next = timer_reg + bref_pkg::TIMER_W'(1);
        end

        if (shift_en && !has_next)
        begin
            ovf_next = 1'b0;
        end
        else
        begin
            ovf_next = ovf_reg || tok[MAX].valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bref_pkg::ST_FILL;
            count_reg <= '0;
            bound_reg <= '0;
            timer_reg <= bref_pkg::TIMER_W'(bref_pkg::DRAIN_CYCLES);
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            bound_reg <= bound_next;
            timer_reg <= timer_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef SYNTHESIS
    a_capacity_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} + {1'b0, bound_reg}) <= (bref_pkg::CNT_W + 1)'(MAX))
        else $error("stored and in-flight buckets exceed capacity");

    a_overflow_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        tok[MAX].valid |-> full)
        else $error("bucket left the chain while the store had room");

    a_emit_quiet_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bref_pkg::ST_EMIT) |-> (settle_vec == '0))
        else $error("bucket still travelling during emission");

    a_final_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
        (emit.load && emit.last) |=> (state_reg == bref_pkg::ST_FILL && count_reg == '0))
        else $error("store not emptied after the final end point");
`endif

endmodule
